// ----- rtl/fcba_pkg.sv -----
package fcba_pkg;

  // field widths
  localparam int BLK_W  = 8;
  localparam int NAME_W = 64;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 3;
  localparam int DS_W   = 8;

  // default geometry
  localparam int DEF_NUM_BLOCKS  = 256;
  localparam int DEF_DIR_ENTRIES = 16;

  // name held by an unused directory entry
  localparam logic [NAME_W-1:0] EMPTY_NAME = 64'h7878_7878_7878_7878;

  // lowest block number a format may hand out
  localparam logic [DS_W-1:0] MIN_DATA_START = 8'd2;

  // configuration register word index
  localparam logic REG_IDX_DATA_START = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_FORMAT = 3'd0,
    ACT_CREATE = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_APPEND = 3'd3,
    ACT_DELETE = 3'd4,
    ACT_CHECK  = 3'd5,
    ACT_NEXT   = 3'd6
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_EXISTS   = 3'd1,
    ST_NOFILE   = 3'd2,
    ST_NOTEMPTY = 3'd3,
    ST_DIRFULL  = 3'd4,
    ST_DISKFULL = 3'd5,
    ST_NOTIN    = 3'd6
  } status_e;

  // datapath micro-operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SWEEP,
    OP_SCAN,
    OP_CREATE,
    OP_REMOVE,
    OP_RD_HEAD,
    OP_A_TAKE,
    OP_A_POP,
    OP_A_CLR,
    OP_A_FIRST,
    OP_WALK_INIT,
    OP_A_WALK,
    OP_C_WALK,
    OP_RD_BLK,
    OP_D_UNLINK,
    OP_D_HEAD,
    OP_D_PUSH,
    OP_N_RES,
    OP_DELIVER
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    logic    st_we;
    status_e st;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic sweep_last;
    logic scan_done;
    logic name_empty;
    logic found;
    logic has_empty;
    logic first_zero;
    logic a_bad;
    logic a_end;
    logic c_miss;
    logic c_hit;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/fat_chain_block_allocator.sv -----
// Block allocator over a file allocation table. Table entry 0 heads the free
// list, every other entry links to the next block of its chain (0 ends it),
// and a directory of DIR_ENTRIES named files holds each file's first block.
// One item is taken at a time and gives exactly one result. Format writes
// one table entry per cycle, and the unused action goes straight to its
// result. Every other action first scans the whole directory and decides.
// Check, next and delete then walk the chain one entry per cycle. Append
// finishes without a walk when the disk is full or the file is empty, and
// otherwise walks to the chain tail the same way. The single-port table
// read in the walk sets the rate. After reset a clearing pass zeroes the
// table, and no item is taken until it ends. A result waiting in the output
// register does not hold off the next item; only that item's delivery waits
// until the register is free.
module fat_chain_block_allocator import fcba_pkg::*; #(
  parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS,
  parameter int DIR_ENTRIES = DEF_DIR_ENTRIES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [NAME_W-1:0] file_name_i,
  input  logic [BLK_W-1:0]  block_number_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [STAT_W-1:0] status_o,
  output logic [BLK_W-1:0]  block_result_o
);

  logic [DS_W-1:0] data_start_q;
  logic            reg_sel;
  dp_cmd_t         cmd;
  dp_stat_t        stat;

  // configuration register
  assign reg_sel = (paddr[2] == REG_IDX_DATA_START);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(32-DS_W){1'b0}}, data_start_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_start_q <= MIN_DATA_START;
    end else if (psel && penable && pwrite && reg_sel) begin
      data_start_q <= pwdata[DS_W-1:0];
    end
  end

  fcba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (action_i),
    .in_stall_o  (in_stall_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fcba_dp #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .DIR_ENTRIES (DIR_ENTRIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_action_i    (action_i),
    .in_name_i      (file_name_i),
    .in_blk_i       (block_number_i),
    .data_start_i   (data_start_q),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .block_result_o (block_result_o)
  );

endmodule

// ----- rtl/fcba_dp.sv -----
module fcba_dp import fcba_pkg::*; #(
  parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS,
  parameter int DIR_ENTRIES = DEF_DIR_ENTRIES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ACT_W-1:0]  in_action_i,
  input  logic [NAME_W-1:0] in_name_i,
  input  logic [BLK_W-1:0]  in_blk_i,
  input  logic [DS_W-1:0]   data_start_i,
  input  dp_cmd_t           cmd_i,
  output dp_stat_t          stat_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic [STAT_W-1:0] status_o,
  output logic [BLK_W-1:0]  block_result_o
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int DW = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
  localparam int KW = $clog2(DIR_ENTRIES + 1);
  localparam logic [BLK_W:0] NB_V = (BLK_W+1)'(NUM_BLOCKS);
  localparam logic [AW:0]    NB_C = (AW+1)'(NUM_BLOCKS);
  localparam logic [KW-1:0]  DE_C = KW'(DIR_ENTRIES);

  // storage
  logic [BLK_W-1:0]  tbl_mem [NUM_BLOCKS];
  logic [NAME_W-1:0] dn_mem  [DIR_ENTRIES];
  logic [BLK_W-1:0]  df_mem  [DIR_ENTRIES];
  logic [DIR_ENTRIES-1:0] dv_q;

  // captured item and result
  logic [ACT_W-1:0]  act_q;
  logic [NAME_W-1:0] name_q;
  logic [BLK_W-1:0]  blk_q;
  status_e           st_q;
  logic [BLK_W-1:0]  res_q;

  // sequencing registers
  logic [AW:0]      cnt_q;
  logic             fmt_q;
  logic [KW-1:0]    k_q;
  logic             sv_q;
  logic [DW-1:0]    si_q;
  logic             found_q;
  logic [DW-1:0]    f_q;
  logic [BLK_W-1:0] first_q;
  logic             hasemp_q;
  logic [DW-1:0]    e_q;
  logic [BLK_W-1:0] cur_q;
  logic [BLK_W-1:0] prev_q;
  logic             mem_q;
  logic [BLK_W-1:0] a_q;

  // memory read data
  logic [BLK_W-1:0]  tbl_rd_q;
  logic [NAME_W-1:0] dn_rd_q;
  logic [BLK_W-1:0]  df_rd_q;
  logic              dv_rd_q;

  // output register
  logic              out_valid_q;
  logic [STAT_W-1:0] out_st_q;
  logic [BLK_W-1:0]  out_res_q;

  logic [BLK_W-1:0]  rd_m;
  logic [NAME_W-1:0] eff_name;
  logic [BLK_W-1:0]  eff_first;
  logic [BLK_W:0]    start_x;
  logic [BLK_W:0]    cnt_x;
  logic [BLK_W:0]    cnt_p1;
  logic [BLK_W-1:0]  sweep_val;
  logic [BLK_W-1:0]  c_blk;
  logic              c_miss;
  logic              c_hit;
  logic              a_end;
  logic [BLK_W-1:0]  link_tgt;
  logic              scan_en;

  logic              tw_en;
  logic [BLK_W-1:0]  tw_addr;
  logic [BLK_W-1:0]  tw_data;
  logic [BLK_W-1:0]  tr_addr;
  logic              dn_we;
  logic              df_we;
  logic [DW-1:0]     dw_addr;
  logic [BLK_W-1:0]  df_data;

  // links at or beyond the table size read as end of chain
  assign rd_m      = ({1'b0, tbl_rd_q} < NB_V) ? tbl_rd_q : '0;
  assign eff_name  = dv_rd_q ? dn_rd_q : EMPTY_NAME;
  assign eff_first = dv_rd_q ? df_rd_q : '0;

  // format sweep value
  assign start_x = (data_start_i < MIN_DATA_START) ? {1'b0, MIN_DATA_START}
                                                   : {1'b0, data_start_i};
  assign cnt_x   = (BLK_W+1)'(cnt_q);
  assign cnt_p1  = cnt_x + 1'b1;

  always_comb begin
    sweep_val = '0;
    if (fmt_q) begin
      if (cnt_x == '0) begin
        sweep_val = (start_x < NB_V) ? start_x[BLK_W-1:0] : '0;
      end else if ((cnt_x >= start_x) && (cnt_p1 < NB_V)) begin
        sweep_val = cnt_p1[BLK_W-1:0];
      end
    end
  end

  // membership walk candidate
  assign c_blk  = mem_q ? rd_m : cur_q;
  assign c_miss = (cnt_q == NB_C) || (c_blk == '0) || ({1'b0, c_blk} >= NB_V);
  assign c_hit  = !c_miss && (c_blk == blk_q);

  // tail walk for append
  assign a_end    = mem_q && ((rd_m == '0) || (cnt_q == NB_C));
  assign link_tgt = (rd_m == '0) ? cur_q : rd_m;

  assign scan_en = (k_q < DE_C);

  // memory port control per micro-operation
  always_comb begin
    tw_en   = 1'b0;
    tw_addr = '0;
    tw_data = '0;
    tr_addr = '0;
    dn_we   = 1'b0;
    df_we   = 1'b0;
    dw_addr = f_q;
    df_data = '0;
    case (cmd_i.op)
      OP_SWEEP: begin
        tw_en   = 1'b1;
        tw_addr = BLK_W'(cnt_q[AW-1:0]);
        tw_data = sweep_val;
      end
      OP_CREATE: begin
        dn_we   = 1'b1;
        df_we   = 1'b1;
        dw_addr = e_q;
      end
      OP_A_TAKE: tr_addr = tbl_rd_q;
      OP_A_POP: begin
        tw_en   = 1'b1;
        tw_data = rd_m;
      end
      OP_A_CLR: begin
        tw_en   = 1'b1;
        tw_addr = a_q;
      end
      OP_A_FIRST: begin
        df_we   = 1'b1;
        df_data = a_q;
      end
      OP_A_WALK: begin
        if (!mem_q) begin
          tr_addr = cur_q;
        end else if (a_end) begin
          tw_en   = 1'b1;
          tw_addr = link_tgt;
          tw_data = a_q;
        end else begin
          tr_addr = rd_m;
        end
      end
      OP_C_WALK: tr_addr = c_blk;
      OP_RD_BLK: tr_addr = blk_q;
      OP_D_UNLINK: begin
        if (prev_q == '0) begin
          df_we   = 1'b1;
          df_data = rd_m;
        end else begin
          tw_en   = 1'b1;
          tw_addr = prev_q;
          tw_data = rd_m;
        end
      end
      OP_D_HEAD: begin
        tw_en   = 1'b1;
        tw_addr = blk_q;
        tw_data = tbl_rd_q;
      end
      OP_D_PUSH: begin
        tw_en   = 1'b1;
        tw_data = blk_q;
      end
      default: ;
    endcase
  end

  // allocation table
  always_ff @(posedge clk_i) begin
    if (tw_en && ({1'b0, tw_addr} < NB_V)) begin
      tbl_mem[tw_addr[AW-1:0]] <= tw_data;
    end
    tbl_rd_q <= tbl_mem[tr_addr[AW-1:0]];
  end

  // directory
  always_ff @(posedge clk_i) begin
    if (dn_we) begin
      dn_mem[dw_addr] <= name_q;
    end
    if (df_we) begin
      df_mem[dw_addr] <= df_data;
    end
    dn_rd_q <= dn_mem[k_q[DW-1:0]];
    df_rd_q <= df_mem[k_q[DW-1:0]];
    dv_rd_q <= dv_q[k_q[DW-1:0]];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      fmt_q       <= 1'b0;
      k_q         <= '0;
      sv_q        <= 1'b0;
      mem_q       <= 1'b0;
      dv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_DELIVER) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_CAPTURE: begin
          cnt_q <= '0;
          fmt_q <= 1'b1;
          k_q   <= '0;
          sv_q  <= 1'b0;
          if (in_action_i == ACT_FORMAT) begin
            dv_q <= '0;
          end
        end
        OP_SWEEP: cnt_q <= cnt_q + 1'b1;
        OP_SCAN: begin
          sv_q <= scan_en;
          if (scan_en) begin
            k_q <= k_q + 1'b1;
          end
        end
        OP_CREATE: dv_q[e_q] <= 1'b1;
        OP_REMOVE: dv_q[f_q] <= 1'b0;
        OP_WALK_INIT: begin
          cnt_q <= '0;
          mem_q <= 1'b0;
        end
        OP_A_WALK: begin
          if (!mem_q || !a_end) begin
            cnt_q <= cnt_q + 1'b1;
            mem_q <= 1'b1;
          end
        end
        OP_C_WALK: begin
          if (!c_miss && !c_hit) begin
            cnt_q <= cnt_q + 1'b1;
            mem_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // item payload and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.st_we) begin
      st_q <= cmd_i.st;
    end
    case (cmd_i.op)
      OP_CAPTURE: begin
        act_q    <= in_action_i;
        name_q   <= in_name_i;
        blk_q    <= in_blk_i;
        st_q     <= ST_OK;
        res_q    <= '0;
        found_q  <= 1'b0;
        hasemp_q <= 1'b0;
      end
      OP_SCAN: begin
        si_q <= k_q[DW-1:0];
        if (sv_q) begin
          if (!found_q && (eff_name == name_q)) begin
            found_q <= 1'b1;
            f_q     <= si_q;
            first_q <= eff_first;
          end
          if (!hasemp_q && (eff_name == EMPTY_NAME)) begin
            hasemp_q <= 1'b1;
            e_q      <= si_q;
          end
        end
      end
      OP_A_TAKE: a_q <= tbl_rd_q;
      OP_A_CLR: res_q <= a_q;
      OP_WALK_INIT: begin
        cur_q  <= first_q;
        prev_q <= '0;
      end
      OP_A_WALK: begin
        if (mem_q && !a_end) begin
          cur_q <= rd_m;
        end
      end
      OP_C_WALK: begin
        if (!c_miss && !c_hit) begin
          prev_q <= c_blk;
        end
      end
      OP_N_RES: res_q <= rd_m;
      OP_DELIVER: begin
        out_st_q  <= st_q;
        out_res_q <= res_q;
      end
      default: ;
    endcase
  end

  // status to the controller
  always_comb begin
    stat_o.act        = act_q;
    stat_o.sweep_last = (cnt_q == NB_C - 1'b1);
    stat_o.scan_done  = (k_q == DE_C) && !sv_q;
    stat_o.name_empty = (name_q == EMPTY_NAME);
    stat_o.found      = found_q;
    stat_o.has_empty  = hasemp_q;
    stat_o.first_zero = (first_q == '0);
    stat_o.a_bad      = (tbl_rd_q == '0) || ({1'b0, tbl_rd_q} >= NB_V);
    stat_o.a_end      = a_end;
    stat_o.c_miss     = c_miss;
    stat_o.c_hit      = c_hit;
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign block_result_o = out_res_q;

endmodule

// ----- rtl/fcba_ctrl.sv -----
module fcba_ctrl import fcba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ACT_W-1:0] in_action_i,
  output logic             in_stall_o,
  input  dp_stat_t         stat_i,
  output dp_cmd_t          cmd_o
);

  typedef enum logic [20:0] {
    S_CLR      = 21'h000001,
    S_IDLE     = 21'h000002,
    S_FMT      = 21'h000004,
    S_SCAN     = 21'h000008,
    S_DISP     = 21'h000010,
    S_CREATE   = 21'h000020,
    S_REMOVE   = 21'h000040,
    S_A_TAKE   = 21'h000080,
    S_A_POP    = 21'h000100,
    S_A_CLR    = 21'h000200,
    S_A_FIRST  = 21'h000400,
    S_A_WINIT  = 21'h000800,
    S_A_WALK   = 21'h001000,
    S_C_WALK   = 21'h002000,
    S_RD_BLK   = 21'h004000,
    S_N_RES    = 21'h008000,
    S_D_UNLINK = 21'h010000,
    S_D_HEAD   = 21'h020000,
    S_D_PUSH   = 21'h040000,
    S_FIN      = 21'h080000,
    S_SPARE    = 21'h100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // next state and datapath command
  always_comb begin
    state_d = state_q;
    cmd_o   = '{op: OP_NONE, st_we: 1'b0, st: ST_OK};
    case (state_q)
      // table clearing pass after reset
      S_CLR: begin
        cmd_o.op = OP_SWEEP;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          case (in_action_i)
            ACT_FORMAT: state_d = S_FMT;
            ACT_CREATE, ACT_REMOVE, ACT_APPEND,
            ACT_DELETE, ACT_CHECK, ACT_NEXT: state_d = S_SCAN;
            default: state_d = S_FIN;
          endcase
        end
      end
      S_FMT: begin
        cmd_o.op = OP_SWEEP;
        if (stat_i.sweep_last) begin
          state_d = S_FIN;
        end
      end
      S_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (stat_i.scan_done) begin
          state_d = S_DISP;
        end
      end
      // decide on the directory lookup
      S_DISP: begin
        cmd_o.st_we = 1'b1;
        cmd_o.st    = ST_OK;
        state_d     = S_FIN;
        if (stat_i.name_empty) begin
          cmd_o.st = (stat_i.act == ACT_CREATE) ? ST_EXISTS : ST_NOFILE;
        end else if (stat_i.act == ACT_CREATE) begin
          if (stat_i.found) begin
            cmd_o.st = ST_EXISTS;
          end else if (!stat_i.has_empty) begin
            cmd_o.st = ST_DIRFULL;
          end else begin
            state_d = S_CREATE;
          end
        end else if (!stat_i.found) begin
          cmd_o.st = ST_NOFILE;
        end else begin
          case (stat_i.act)
            ACT_REMOVE: begin
              if (stat_i.first_zero) begin
                state_d = S_REMOVE;
              end else begin
                cmd_o.st = ST_NOTEMPTY;
              end
            end
            ACT_APPEND: begin
              cmd_o.op = OP_RD_HEAD;
              state_d  = S_A_TAKE;
            end
            default: begin
              cmd_o.op = OP_WALK_INIT;
              state_d  = S_C_WALK;
            end
          endcase
        end
      end
      S_CREATE: begin
        cmd_o.op = OP_CREATE;
        state_d  = S_FIN;
      end
      S_REMOVE: begin
        cmd_o.op = OP_REMOVE;
        state_d  = S_FIN;
      end
      // append: pop the free list head
      S_A_TAKE: begin
        if (stat_i.a_bad) begin
          cmd_o.st_we = 1'b1;
          cmd_o.st    = ST_DISKFULL;
          state_d     = S_FIN;
        end else begin
          cmd_o.op = OP_A_TAKE;
          state_d  = S_A_POP;
        end
      end
      S_A_POP: begin
        cmd_o.op = OP_A_POP;
        state_d  = S_A_CLR;
      end
      S_A_CLR: begin
        cmd_o.op = OP_A_CLR;
        state_d  = stat_i.first_zero ? S_A_FIRST : S_A_WINIT;
      end
      S_A_FIRST: begin
        cmd_o.op = OP_A_FIRST;
        state_d  = S_FIN;
      end
      S_A_WINIT: begin
        cmd_o.op = OP_WALK_INIT;
        state_d  = S_A_WALK;
      end
      S_A_WALK: begin
        cmd_o.op = OP_A_WALK;
        if (stat_i.a_end) begin
          state_d = S_FIN;
        end
      end
      // membership walk
      S_C_WALK: begin
        cmd_o.op = OP_C_WALK;
        if (stat_i.c_miss) begin
          cmd_o.st_we = 1'b1;
          cmd_o.st    = ST_NOTIN;
          state_d     = S_FIN;
        end else if (stat_i.c_hit) begin
          state_d = (stat_i.act == ACT_CHECK) ? S_FIN : S_RD_BLK;
        end
      end
      S_RD_BLK: begin
        cmd_o.op = OP_RD_BLK;
        state_d  = (stat_i.act == ACT_NEXT) ? S_N_RES : S_D_UNLINK;
      end
      S_N_RES: begin
        cmd_o.op = OP_N_RES;
        state_d  = S_FIN;
      end
      // delete: unlink then push on the free list
      S_D_UNLINK: begin
        cmd_o.op = OP_D_UNLINK;
        state_d  = S_D_HEAD;
      end
      S_D_HEAD: begin
        cmd_o.op = OP_D_HEAD;
        state_d  = S_D_PUSH;
      end
      S_D_PUSH: begin
        cmd_o.op = OP_D_PUSH;
        state_d  = S_FIN;
      end
      // hand the result to the output register
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_DELIVER;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
